// ===== hw/rtl/pfe_pkg.sv =====
package pfe_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_POW   = 8'h24;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MOD,
      OP_POW
   } op_type;

   // request and reply between the top level and the arithmetic unit
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_rsp_type;

endpackage

// ===== hw/rtl/pfe_ram.sv =====
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/pfe_alu.sv =====
module pfe_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pfe_pkg::alu_req_type ctl,
   input  logic [31:0]          left,
   input  logic [31:0]          right,
   output pfe_pkg::alu_rsp_type sts,
   output logic [31:0]          result
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_POW_MUL,
      S_POW_SQR,
      S_DONE
   } state_type;

   state_type        state_ff;
   pfe_pkg::op_type  op_ff;
   logic [31:0]      a_ff;      // dividend shift / power base
   logic [31:0]      b_ff;      // divisor magnitude / exponent
   logic [31:0]      q_ff;      // quotient / power accumulator
   logic [32:0]      r_ff;      // partial remainder
   logic [5:0]       cnt_ff;
   logic             neg_a_ff;
   logic             neg_b_ff;
   logic [31:0]      result_ff;
   logic             done_ff;
   logic             dz_ff;

   logic [31:0] mag_l;
   logic [31:0] mag_r;
   logic [32:0] trial;
   logic [32:0] r_shift;

   assign mag_l   = left[31]  ? 32'(-left)  : left;
   assign mag_r   = right[31] ? 32'(-right) : right;
   assign r_shift = {r_ff[31:0], a_ff[31]};
   assign trial   = r_shift - {1'b0, b_ff};

   assign sts.done     = done_ff;
   assign sts.div_zero = dz_ff;
   assign result       = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         dz_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         dz_ff   <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  op_ff <= ctl.op;
                  case (ctl.op)
                     pfe_pkg::OP_ADD: begin
                        result_ff <= left + right;
                        done_ff   <= 1'b1;
                     end
                     pfe_pkg::OP_SUB: begin
                        result_ff <= left - right;
                        done_ff   <= 1'b1;
                     end
                     pfe_pkg::OP_MUL: begin
                        result_ff <= 32'(left * right);
                        done_ff   <= 1'b1;
                     end
                     pfe_pkg::OP_DIV, pfe_pkg::OP_MOD: begin
                        if (right == 32'd0) begin
                           result_ff <= 32'd0;
                           done_ff   <= 1'b1;
                           dz_ff     <= 1'b1;
                        end else begin
                           a_ff     <= mag_l;
                           b_ff     <= mag_r;
                           q_ff     <= 32'd0;
                           r_ff     <= 33'd0;
                           cnt_ff   <= 6'd32;
                           neg_a_ff <= left[31];
                           neg_b_ff <= right[31];
                           state_ff <= S_DIV;
                        end
                     end
                     default: begin
                        if (right[31]) begin
                           if (left == 32'd1) begin
                              result_ff <= 32'd1;
                           end else if (left == 32'hFFFF_FFFF) begin
                              result_ff <= right[0] ? 32'hFFFF_FFFF : 32'd1;
                           end else begin
                              result_ff <= 32'd0;
                           end
                           done_ff <= 1'b1;
                        end else begin
                           a_ff     <= left;
                           b_ff     <= right;
                           q_ff     <= 32'd1;
                           state_ff <= S_POW_MUL;
                        end
                     end
                  endcase
               end
            end
            S_DIV: begin
               a_ff <= {a_ff[30:0], 1'b0};
               if (!trial[32]) begin
                  r_ff <= trial;
                  q_ff <= {q_ff[30:0], 1'b1};
               end else begin
                  r_ff <= r_shift;
                  q_ff <= {q_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  state_ff <= S_DONE;
               end
            end
            S_POW_MUL: begin
               if (b_ff == 32'd0) begin
                  result_ff <= q_ff;
                  done_ff   <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  if (b_ff[0]) begin
                     q_ff <= 32'(q_ff * a_ff);
                  end
                  state_ff <= S_POW_SQR;
               end
            end
            S_POW_SQR: begin
               a_ff     <= 32'(a_ff * a_ff);
               b_ff     <= {1'b0, b_ff[31:1]};
               state_ff <= S_POW_MUL;
            end
            S_DONE: begin
               // apply signs to the magnitudes
               if (op_ff == pfe_pkg::OP_MOD) begin
                  result_ff <= neg_a_ff ? 32'(-r_ff[31:0]) : r_ff[31:0];
               end else begin
                  result_ff <= (neg_a_ff != neg_b_ff) ? 32'(-q_ff) : q_ff;
               end
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// Postfix evaluator: one ASCII character per item, stack of signed 32-bit
// operands in a one-port-read synchronous RAM. Blank and digit items are
// handled in the idle state; an operator pops both operands (one RAM read
// each) in two pop states, then the arithmetic: direct for + - * and for a
// zero divisor, one quotient bit a cycle for / and %, and square and
// multiply per exponent bit for power. A new item is taken only once the
// last is through. The item marked last adds a read for the final pop and
// a load of the output register; the result then waits in that register
// while the next item is taken. Reset needs no clearing pass.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_symbol,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic        rsp_underflow,
   output logic        rsp_overflow,
   output logic        rsp_bad_operator,
   output logic        rsp_divide_by_zero
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_R,
      S_POP_L,
      S_CALC,
      S_FINAL,
      S_EMIT
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   depth_ff;
   logic            unf_ff, ovf_ff, dz_ff, abort_ff;
   logic            last_ff;
   pfe_pkg::op_type op_ff;
   logic [31:0]     right_ff;
   logic            alu_busy_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [31:0]     wr_data;
   logic [AW-1:0]   rd_addr;
   logic [31:0]     rd_data;

   pfe_pkg::alu_req_type alu_ctl;
   pfe_pkg::alu_rsp_type alu_sts;
   logic [31:0]          alu_res;
   logic [31:0]          left_val;
   logic                 pop_empty;
   logic                 have_top;

   pfe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   pfe_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .left  (left_val),
      .right (right_ff),
      .sts   (alu_sts),
      .result(alu_res)
   );

   logic is_blank, is_digit, is_op;
   pfe_pkg::op_type sym_op;

   always_comb begin
      is_blank = (req_symbol == pfe_pkg::CHAR_NUL) || (req_symbol == pfe_pkg::CHAR_SPACE)
              || (req_symbol == pfe_pkg::CHAR_TAB);
      is_digit = (req_symbol >= pfe_pkg::CHAR_ZERO) && (req_symbol <= pfe_pkg::CHAR_NINE);
      is_op    = 1'b1;
      case (req_symbol)
         pfe_pkg::CHAR_PLUS:  sym_op = pfe_pkg::OP_ADD;
         pfe_pkg::CHAR_MINUS: sym_op = pfe_pkg::OP_SUB;
         pfe_pkg::CHAR_STAR:  sym_op = pfe_pkg::OP_MUL;
         pfe_pkg::CHAR_SLASH: sym_op = pfe_pkg::OP_DIV;
         pfe_pkg::CHAR_PCT:   sym_op = pfe_pkg::OP_MOD;
         pfe_pkg::CHAR_POW:   sym_op = pfe_pkg::OP_POW;
         default: begin
            sym_op = pfe_pkg::OP_ADD;
            is_op  = 1'b0;
         end
      endcase
   end

   // the entry read in the previous cycle, or 0 on an empty pop
   assign have_top  = depth_ff != '0;
   assign pop_empty = !have_top;
   assign rd_addr   = AW'(depth_ff - CW'(1));

   logic pend_empty_ff;
   assign left_val = pend_empty_ff ? 32'd0 : rd_data;

   assign req_ready = (state_ff == S_IDLE);
   logic accept;
   assign accept = req_valid && req_ready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(depth_ff);
      wr_data = 32'(req_symbol - pfe_pkg::CHAR_ZERO);
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_ff;
      if (state_ff == S_IDLE && accept && !abort_ff && is_digit
          && depth_ff < CW'(STACK_DEPTH)) begin
         wr_en = 1'b1;
      end
      if (state_ff == S_CALC && !alu_busy_ff) begin
         alu_ctl.start = 1'b1;
      end
      if (state_ff == S_CALC && alu_busy_ff && alu_sts.done
          && depth_ff < CW'(STACK_DEPTH)) begin
         wr_en   = 1'b1;
         wr_data = alu_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         depth_ff    <= '0;
         unf_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         dz_ff       <= 1'b0;
         abort_ff    <= 1'b0;
         rsp_valid   <= 1'b0;
         alu_busy_ff <= 1'b0;
      end else begin
         // the emit state reloads the output register itself
         if (rsp_valid && rsp_ready && state_ff != S_EMIT) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  last_ff <= req_last;
                  op_ff   <= sym_op;
                  if (abort_ff || is_blank) begin
                     if (req_last) state_ff <= S_FINAL;
                  end else if (is_digit) begin
                     if (depth_ff < CW'(STACK_DEPTH)) begin
                        depth_ff <= depth_ff + CW'(1);
                     end else begin
                        ovf_ff <= 1'b1;
                     end
                     if (req_last) state_ff <= S_FINAL;
                  end else if (is_op) begin
                     state_ff <= S_POP_R;
                  end else begin
                     abort_ff <= 1'b1;
                     if (req_last) state_ff <= S_FINAL;
                  end
               end
            end
            S_POP_R: begin
               // read of the top entry was issued in the previous cycle
               pend_empty_ff <= pop_empty;
               if (pop_empty) unf_ff <= 1'b1;
               else depth_ff <= depth_ff - CW'(1);
               state_ff <= S_POP_L;
            end
            S_POP_L: begin
               right_ff      <= left_val;
               pend_empty_ff <= pop_empty;
               if (pop_empty) unf_ff <= 1'b1;
               else depth_ff <= depth_ff - CW'(1);
               state_ff <= S_CALC;
            end
            S_CALC: begin
               if (!alu_busy_ff) begin
                  alu_busy_ff <= 1'b1;
               end else if (alu_sts.done) begin
                  alu_busy_ff <= 1'b0;
                  if (alu_sts.div_zero) dz_ff <= 1'b1;
                  if (depth_ff < CW'(STACK_DEPTH)) begin
                     depth_ff <= depth_ff + CW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  state_ff <= last_ff ? S_FINAL : S_IDLE;
               end
            end
            S_FINAL: begin
               // read address now settles on the top entry
               pend_empty_ff <= pop_empty;
               if (pop_empty) unf_ff <= 1'b1;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid || rsp_ready) begin
                  rsp_value          <= left_val;
                  rsp_underflow      <= unf_ff;
                  rsp_overflow       <= ovf_ff;
                  rsp_bad_operator   <= abort_ff;
                  rsp_divide_by_zero <= dz_ff;
                  rsp_valid          <= 1'b1;
                  depth_ff <= '0;
                  unf_ff   <= 1'b0;
                  ovf_ff   <= 1'b0;
                  dz_ff    <= 1'b0;
                  abort_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
